// File: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared constants and types for the palindromic substring counter
// Sizes of the cell row, the bit-count tree and the running total.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned SUM_W   = TOTAL_W + 1;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};

  // The hit vector is counted in groups of eight bits.
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned GRP_N    = (MAX_LEN + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_CW   = $clog2(GRP_SIZE + 1);
  localparam int unsigned CNT_W    = $clog2(GRP_N * GRP_SIZE + 1);

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic take;   // store or compare the new byte
    logic clear;  // end of string: empty the cell
  } psc_ctl_t;

  // Item tag that travels alongside the bit count.
  typedef struct packed {
    logic valid;
    logic fin;
    logic ovf;
  } psc_tag_t;

endpackage

// File: rtl/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell: one position of the string
// Holds one byte and the flag that the text from here to the end is a
// palindrome; compares its byte with the new one.
// ----------------------------------------------------------------------------
module psc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psc_pkg::psc_ctl_t     ctl_i,
  input  logic [psc_pkg::SYM_W-1:0] symbol_i,
  input  logic                  prev_occ_i,
  input  logic                  next_inner_i,
  output logic                  occ_o,
  output logic                  inner_o,
  output logic                  hit_o
);
  import psc_pkg::*;

  logic             occ_q, occ_d;
  logic             mask_q, mask_d;
  logic [SYM_W-1:0] hist_q;

  // A palindrome ending at the new byte starts here when the bytes match and
  // the inner part (held by the upper neighbor) is a palindrome or empty.
  assign hit_o   = occ_q && next_inner_i && (hist_q == symbol_i);
  assign inner_o = mask_q || !occ_q;
  assign occ_o   = occ_q;

  always_comb begin
    occ_d  = occ_q;
    mask_d = mask_q;
    if (ctl_i.clear) begin
      occ_d  = 1'b0;
      mask_d = 1'b0;
    end else if (ctl_i.take) begin
      if (occ_q) begin
        mask_d = hit_o;
      end else if (prev_occ_i) begin
        occ_d  = 1'b1;
        mask_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      mask_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take && !ctl_i.clear && !occ_q && prev_occ_i) begin
      hist_q <= symbol_i;
    end
  end

endmodule

// File: rtl/psc_bitcount.sv
// ----------------------------------------------------------------------------
// psc_bitcount: two-stage population count of the cell hits
// Stage one counts groups of eight bits, stage two adds the group counts.
// ----------------------------------------------------------------------------
module psc_bitcount (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  psc_pkg::psc_tag_t           tag_i,
  input  logic [psc_pkg::MAX_LEN-1:0] hits_i,
  output psc_pkg::psc_tag_t           tag_o,
  output logic [psc_pkg::CNT_W-1:0]   cnt_o
);
  import psc_pkg::*;

  logic [GRP_N*GRP_SIZE-1:0] hits_pad;
  logic [GRP_CW-1:0]         grp_d [GRP_N];
  logic [GRP_CW-1:0]         grp_q [GRP_N];
  logic [CNT_W-1:0]          cnt_d, cnt_q;
  psc_tag_t                  tag1_q, tag2_q;

  assign hits_pad = (GRP_N*GRP_SIZE)'(hits_i);

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < GRP_SIZE; b++) begin
        grp_d[g] = grp_d[g] + GRP_CW'(hits_pad[g*GRP_SIZE + b]);
      end
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int g = 0; g < GRP_N; g++) begin
      cnt_d = cnt_d + CNT_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
      cnt_q <= cnt_d;
    end
  end

  assign tag_o = tag2_q;
  assign cnt_o = cnt_q;

endmodule

// File: rtl/palindromic_substring_counter.sv
// ----------------------------------------------------------------------------
// palindromic_substring_counter: counts palindromic substrings of a string
// Bytes enter a row of cells; each new byte is compared against every stored
// byte at once, and the hits are counted and added to a running total.
//
//   Channel  Dir  tdata                     tuser      tlast
//   s_axis   in   [7:0] symbol              -          is_final
//   m_axis   out  [10:0] palindrome_count   overflow   -
//
// One byte is taken per cycle unless a waiting result holds s_axis_tready low.
// The result of a string passes through the two bit-count stages and the output
// register before it is presented on m_axis.
// Reset empties all cells, the count pipeline and the output register.
// While a result waits on m_axis, s_axis_tready is low and the pipeline holds.
// ----------------------------------------------------------------------------
module palindromic_substring_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [psc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] symbol
  input  logic                            s_axis_tlast,   // is_final
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [psc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [10:0] palindrome_count
  output logic                            m_axis_tuser    // [0] overflow
);
  import psc_pkg::*;

  logic               en;
  logic               accept;
  logic               full;
  logic               too_long_q, too_long_d;
  psc_ctl_t           ctl;
  psc_tag_t           tag_in, tag_out;
  logic [MAX_LEN-1:0] occ, inner, hit;
  logic [MAX_LEN-1:0] hits_gated;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W-1:0] total_q, total_d, total_sat;
  logic [SUM_W-1:0]   sum;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_count_q;
  logic               out_ovf_q;

  // The whole pipeline advances unless a result is stalled at the output.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign full          = occ[MAX_LEN-1];

  assign ctl.take  = accept && !full;
  assign ctl.clear = accept && s_axis_tlast;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic prev_occ, next_inner;
    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end
    if (i == MAX_LEN - 1) begin : g_last
      assign next_inner = 1'b1;
    end else begin : g_inner
      assign next_inner = inner[i+1];
    end
    psc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .symbol_i     (s_axis_tdata[SYM_W-1:0]),
      .prev_occ_i   (prev_occ),
      .next_inner_i (next_inner),
      .occ_o        (occ[i]),
      .inner_o      (inner[i]),
      .hit_o        (hit[i])
    );
  end

  assign hits_gated = ctl.take ? hit : '0;

  assign too_long_d = accept && full;

  assign tag_in.valid = accept;
  assign tag_in.fin   = accept && s_axis_tlast;
  assign tag_in.ovf   = too_long_q || too_long_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      too_long_q <= 1'b0;
    end else if (ctl.clear) begin
      too_long_q <= 1'b0;
    end else if (too_long_d) begin
      too_long_q <= 1'b1;
    end
  end

  psc_bitcount u_bitcount (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_in),
    .hits_i (hits_gated),
    .tag_o  (tag_out),
    .cnt_o  (cnt)
  );

  // Saturating running total.
  assign sum       = SUM_W'(total_q) + SUM_W'(cnt);
  assign total_sat = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    total_d = total_q;
    if (en && tag_out.valid) begin
      total_d = tag_out.fin ? '0 : total_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (en && tag_out.valid && tag_out.fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && tag_out.valid && tag_out.fin) begin
      out_count_q <= total_sat;
      out_ovf_q   <= tag_out.ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_count_q);
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: rtl/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the palindromic substring counter
// Watches the stream ports and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [psc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [psc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);
  import psc_pkg::*;

  // A stalled result keeps its value until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Input is held off only while a result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // The padding bits above the count are always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:TOTAL_W] == '0)
    else $error("result padding bits not zero");

  // A byte transfer carries known data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown({s_axis_tdata, s_axis_tlast}))
    else $error("unknown bits in an input transfer");

  // An offered result never shows unknown bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
    else $error("unknown bits in an offered result");

endmodule

bind palindromic_substring_counter psc_checker u_psc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_scoreboard: scoreboard for the palindromic substring counter
// Watches both stream channels. Every byte transfer on the input runs a
// predictor of the palindrome count. Each result transfer is compared with
// the oldest predicted tally.
// ----------------------------------------------------------------------------
module psc_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [psc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [psc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_i,
  input  logic                            m_axis_tuser_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              tallies_checked_o,
  output int                              overflows_checked_o,
  output int                              peak_count_o
);

  import psc_pkg::*;

  typedef struct {
    logic [TOTAL_W-1:0] count;
    logic               ovf;
  } tally_t;

  localparam int unsigned MAX_REPORTS = 20;

  // Predictor state.
  logic [SYM_W-1:0]   seen_bytes [MAX_LEN];
  logic [MAX_LEN-1:0] pal_ends;
  logic [TOTAL_W-1:0] pal_total;
  int unsigned        stored;
  logic               spill;

  tally_t expected_tallies [$];

  assign pending_o = expected_tallies.size();

  task automatic report_mismatch(input string what);
    if (fail_count_o < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count_o++;
  endtask

  task automatic clear_string();
    pal_ends  = '0;
    pal_total = '0;
    stored    = 0;
    spill     = 1'b0;
  endtask

  // A substring i..j is a palindrome when byte i matches the new byte j and
  // the inner part i+1..j-1 is one; an empty or one-byte inner part counts.
  task automatic absorb_byte(input logic [SYM_W-1:0] sym, input logic fin);
    logic [MAX_LEN-1:0] next_ends;
    logic               inner;
    int unsigned        adds;
    int unsigned        sum;
    tally_t             t;
    if (stored < MAX_LEN) begin
      next_ends = '0;
      adds      = 0;
      for (int unsigned i = 0; i < stored; i++) begin
        inner = (i + 1 == stored) ? 1'b1 : pal_ends[i+1];
        if (inner && seen_bytes[i] == sym) begin
          next_ends[i] = 1'b1;
          adds++;
        end
      end
      next_ends[stored]  = 1'b1;
      seen_bytes[stored] = sym;
      stored++;
      pal_ends = next_ends;
      sum = pal_total + adds;
      pal_total = (sum > COUNT_MAX) ? COUNT_MAX : sum[TOTAL_W-1:0];
    end else begin
      spill = 1'b1;
    end
    if (fin) begin
      t.count = pal_total;
      t.ovf   = spill;
      expected_tallies.push_back(t);
      clear_string();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t t;
    if (!rst_ni) begin
      clear_string();
      expected_tallies.delete();
      fail_count_o        = 0;
      tallies_checked_o   = 0;
      overflows_checked_o = 0;
      peak_count_o        = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_tallies.size() == 0) begin
          report_mismatch($sformatf("result count=%0d ovf=%0b with none expected",
                                    m_axis_tdata_i[TOTAL_W-1:0], m_axis_tuser_i));
        end else begin
          t = expected_tallies.pop_front();
          if (m_axis_tdata_i[TOTAL_W-1:0] !== t.count) begin
            report_mismatch($sformatf("palindrome_count %0d, expected %0d",
                                      m_axis_tdata_i[TOTAL_W-1:0], t.count));
          end
          if (m_axis_tuser_i !== t.ovf) begin
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      m_axis_tuser_i, t.ovf));
          end
          if (m_axis_tdata_i[OUT_DATA_W-1:TOTAL_W] !== '0) begin
            report_mismatch($sformatf("tdata padding bits are %0h",
                                      m_axis_tdata_i[OUT_DATA_W-1:TOTAL_W]));
          end
          tallies_checked_o++;
          if (t.ovf) overflows_checked_o++;
          if (int'(t.count) > peak_count_o) peak_count_o = int'(t.count);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        absorb_byte(s_axis_tdata_i[SYM_W-1:0], s_axis_tlast_i);
      end
    end
  end

endmodule

// File: bench/palindromic_substring_counter_tb.sv
// ----------------------------------------------------------------------------
// palindromic_substring_counter_tb: stimulus and verdict for the counter
// Sends a few hand-picked strings, then random strings of mixed shape
// (plain random, two-symbol, single-symbol, mirrored) with random gaps on
// the input and random back-pressure on the output. A scoreboard predicts
// and compares every result.
// ----------------------------------------------------------------------------
module palindromic_substring_counter_tb;

  import psc_pkg::*;

  typedef enum int {
    STR_RANDOM,
    STR_TWO_SYMBOL,
    STR_UNIFORM,
    STR_MIRROR
  } str_shape_e;

  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned IDLE_PCT = 37;
  localparam int unsigned BUF_LEN = 80;
  localparam int unsigned CALM_FROM = 400;
  localparam int unsigned CALM_TO = 560;
  localparam int unsigned TAIL_CYCLES = 10;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;

  int          fail_count;
  int          pending;
  int          tallies_checked;
  int          overflows_checked;
  int          peak_count;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  logic        calm = 1'b0;

  logic [SYM_W-1:0] str_buf [BUF_LEN];

  palindromic_substring_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  psc_scoreboard u_scoreboard (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_axis_tvalid_i     (s_axis_tvalid),
    .s_axis_tready_i     (s_axis_tready),
    .s_axis_tdata_i      (s_axis_tdata),
    .s_axis_tlast_i      (s_axis_tlast),
    .m_axis_tvalid_i     (m_axis_tvalid),
    .m_axis_tready_i     (m_axis_tready),
    .m_axis_tdata_i      (m_axis_tdata),
    .m_axis_tuser_i      (m_axis_tuser),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .tallies_checked_o   (tallies_checked),
    .overflows_checked_o (overflows_checked),
    .peak_count_o        (peak_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending);
      $display("** palindromic_substring_counter: FAILED **");
      $finish;
    end
  end

  // Output back-pressure; none during the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Drives one byte and holds it until the transfer completes.
  // Returns at a falling edge.
  task automatic send_byte(input logic [SYM_W-1:0] sym, input logic fin);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom());
      s_axis_tlast  <= 1'($urandom());
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    calm = (bytes_sent >= CALM_FROM) && (bytes_sent < CALM_TO);
    @(negedge clk_i);
  endtask

  task automatic send_buf(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_byte(str_buf[k], k == len - 1);
    end
    strings_sent++;
  endtask

  task automatic send_shaped(input str_shape_e shape, input int unsigned len);
    logic [SYM_W-1:0] sym_a;
    logic [SYM_W-1:0] sym_b;
    sym_a = SYM_W'($urandom());
    sym_b = SYM_W'($urandom());
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        STR_RANDOM:     str_buf[k] = SYM_W'($urandom_range(255));
        STR_TWO_SYMBOL: str_buf[k] = $urandom_range(1) ? sym_a : sym_b;
        STR_UNIFORM:    str_buf[k] = sym_a;
        default:        str_buf[k] = $urandom_range(2) == 0 ? sym_b : sym_a;
      endcase
    end
    if (shape == STR_MIRROR) begin
      for (int unsigned k = 0; k < len / 2; k++) begin
        str_buf[len-1-k] = str_buf[k];
      end
    end
    send_buf(len);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One-byte strings at both byte extremes give a count of zero.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    strings_sent += 2;
    str_buf[0] = 8'h5a; str_buf[1] = 8'h5a;
    send_buf(2);
    str_buf[0] = 8'ha5; str_buf[1] = 8'h3c; str_buf[2] = 8'ha5;
    send_buf(3);
    str_buf[0] = 8'h00; str_buf[1] = 8'hff; str_buf[2] = 8'h00; str_buf[3] = 8'hff;
    send_buf(4);
    for (int unsigned k = 0; k < 5; k++) str_buf[k] = 8'h81;
    send_buf(5);
    // Distinct bytes with every bit set somewhere: no palindromes.
    for (int unsigned k = 0; k < 8; k++) str_buf[k] = 8'h01 << k;
    send_buf(8);

    // Largest possible count, then a string that runs past the cell row.
    send_shaped(STR_UNIFORM, MAX_LEN);
    send_shaped(STR_UNIFORM, MAX_LEN + 6);

    while (bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(16, 1);
      else if (pick < 92) len = $urandom_range(BUF_LEN - 8, MAX_LEN - 8);
      else if (pick < 96) len = MAX_LEN;
      else                len = MAX_LEN + 1;
      send_shaped(str_shape_e'($urandom_range(STR_MIRROR, STR_RANDOM)), len);
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d strings (%0d bytes) sent, %0d results checked",
             strings_sent, bytes_sent, tallies_checked);
    $display("%0d strings ran past %0d bytes, largest count seen %0d",
             overflows_checked, MAX_LEN, peak_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** palindromic_substring_counter: PASSED **");
    end else begin
      $display("** palindromic_substring_counter: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/psc_pkg.sv
rtl/psc_cell.sv
rtl/psc_bitcount.sv
rtl/palindromic_substring_counter.sv
rtl/psc_checker.sv
bench/psc_checker.sv
bench/palindromic_substring_counter_tb.sv
